FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rmdr_pkg.sv
// ----------------------------------------------------------------------------
// rmdr_pkg
// Shared types and constants of the rational multiply/divide/reduce unit.
// ----------------------------------------------------------------------------
package rmdr_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    localparam logic [1:0] OP_REDUCE = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_DIV    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_SHIFT,
        ST_STRIP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } rmdr_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic shift_both;
        logic strip_u;
        logic gcd_step;
        logic div_start_n;
        logic div_start_d;
        logic div_step;
        logic out_load;
    } rmdr_cmd_t;

    typedef struct packed {
        logic d_zero;
        logic n_zero;
        logic both_even;
        logic u_even;
        logic v_zero;
        logic div_done;
    } rmdr_sts_t;

endpackage

FILE: src/rmdr_datapath.sv
// ----------------------------------------------------------------------------
// rmdr_datapath
// Operand products, binary gcd and restoring division by the gcd.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmdr_datapath
    import rmdr_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rmdr_cmd_t                   cmd,
    output rmdr_sts_t                   sts,
    input  logic [1:0]                  op,
    input  logic [OPERAND_WIDTH-1:0]    a_num,
    input  logic [OPERAND_WIDTH-1:0]    a_den,
    input  logic [OPERAND_WIDTH-1:0]    b_num,
    input  logic [OPERAND_WIDTH-1:0]    b_den,
    output logic [RES_NUM_W-1:0]        res_num,
    output logic [RES_DEN_W-1:0]        res_den,
    output logic                        status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(PW + 1);

    logic [W-1:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic          xn_neg_reg, yn_neg_reg, xd_neg_reg, yd_neg_reg;
    logic          single_reg;
    logic [PW-1:0] nm_reg, dm_reg, u_reg, v_reg, q_reg, r_reg;
    logic [PW-1:0] nq_reg;
    logic          neg_reg;
    logic [CW-1:0] sh_reg, cnt_reg;
    logic [RES_NUM_W-1:0] res_num_reg;
    logic [RES_DEN_W-1:0] res_den_reg;
    logic          status_reg;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    logic [PW-1:0] diff, gg, rs;
    logic          swap;

    assign gg   = u_reg << sh_reg;
    assign swap = u_reg > v_reg;
    assign diff = swap ? (u_reg - v_reg) : (v_reg - u_reg);
    assign rs   = {r_reg[PW-2:0], q_reg[PW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            single_reg <= (op != OP_MUL) && (op != OP_DIV);
            x0_reg     <= mag(a_num);
            xn_neg_reg <= a_num[W-1];
            x1_reg     <= mag(a_den);
            xd_neg_reg <= a_den[W-1];
            if (op == OP_DIV) begin
                y0_reg     <= mag(b_den);
                yn_neg_reg <= b_den[W-1];
                y1_reg     <= mag(b_num);
                yd_neg_reg <= b_num[W-1];
            end else begin
                y0_reg     <= mag(b_num);
                yn_neg_reg <= b_num[W-1];
                y1_reg     <= mag(b_den);
                yd_neg_reg <= b_den[W-1];
            end
        end
        if (cmd.mul) begin
            if (single_reg) begin
                nm_reg  <= PW'(x0_reg);
                dm_reg  <= PW'(x1_reg);
                neg_reg <= xn_neg_reg ^ xd_neg_reg;
            end else begin
                nm_reg  <= PW'(x0_reg) * PW'(y0_reg);
                dm_reg  <= PW'(x1_reg) * PW'(y1_reg);
                neg_reg <= xn_neg_reg ^ yn_neg_reg ^ xd_neg_reg ^ yd_neg_reg;
            end
            sh_reg <= '0;
        end
        if (cmd.mul) begin
            u_reg <= single_reg ? PW'(x0_reg) : PW'(x0_reg) * PW'(y0_reg);
            v_reg <= single_reg ? PW'(x1_reg) : PW'(x1_reg) * PW'(y1_reg);
        end else if (cmd.shift_both) begin
            u_reg  <= u_reg >> 1;
            v_reg  <= v_reg >> 1;
            sh_reg <= sh_reg + 1'b1;
        end else if (cmd.strip_u) begin
            u_reg <= u_reg >> 1;
        end else if (cmd.gcd_step) begin
            if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else begin
                if (swap) u_reg <= v_reg;
                v_reg <= diff;
            end
        end
        if (cmd.div_start_n || cmd.div_start_d) begin
            q_reg   <= cmd.div_start_n ? nm_reg : dm_reg;
            r_reg   <= '0;
            cnt_reg <= CW'(PW);
            if (cmd.div_start_n) u_reg <= gg;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (rs >= u_reg) begin
                r_reg <= rs - u_reg;
                q_reg <= {q_reg[PW-2:0], 1'b1};
            end else begin
                r_reg <= rs;
                q_reg <= {q_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.div_start_d) begin
            nq_reg <= q_reg;
        end
        if (cmd.out_load) begin
            if (sts.d_zero) begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                status_reg  <= 1'b1;
            end else if (sts.n_zero) begin
                res_num_reg <= '0;
                res_den_reg <= RES_DEN_W'(1);
                status_reg  <= 1'b0;
            end else begin
                res_num_reg <= neg_reg ? (~RES_NUM_W'(nq_reg) + 1'b1) : RES_NUM_W'(nq_reg);
                res_den_reg <= RES_DEN_W'(q_reg);
                status_reg  <= 1'b0;
            end
        end
    end

    assign sts.d_zero    = (dm_reg == '0);
    assign sts.n_zero    = (nm_reg == '0);
    assign sts.both_even = !u_reg[0] && !v_reg[0];
    assign sts.u_even    = !u_reg[0];
    assign sts.v_zero    = (v_reg == '0);
    assign sts.div_done  = (cnt_reg == '0);

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

    `ASSERT_NEXT(a_div_count, aclk, aresetn, cmd.div_start_n, cnt_reg == CW'(PW),
        "divider count not loaded")
    `ASSERT_IMPL(a_gcd_odd_u, aclk, aresetn, cmd.gcd_step, u_reg[0],
        "gcd step with even u")

endmodule

FILE: src/rmdr_ctrl.sv
// ----------------------------------------------------------------------------
// rmdr_ctrl
// Sequencer: handshake, product, gcd loop, two divisions, output hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmdr_ctrl
    import rmdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output rmdr_cmd_t   cmd,
    input  rmdr_sts_t   sts
);

    rmdr_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_CHECK;
            ST_CHECK: state_next = (sts.d_zero || sts.n_zero) ? ST_OUT : ST_SHIFT;
            ST_SHIFT: if (!sts.both_even) state_next = ST_STRIP;
            ST_STRIP: if (!sts.u_even) state_next = ST_GCD;
            ST_GCD:   if (sts.v_zero) state_next = ST_DIVN;
            ST_DIVN:  if (sts.div_done) state_next = ST_DIVD;
            ST_DIVD:  if (sts.div_done) state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:  begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL:   cmd.mul = 1'b1;
            ST_CHECK: ;
            ST_SHIFT: cmd.shift_both = sts.both_even;
            ST_STRIP: begin
                cmd.strip_u = sts.u_even;
                cmd.gcd_step = 1'b0;
            end
            ST_GCD:   begin
                cmd.gcd_step    = !sts.v_zero;
                cmd.div_start_n = sts.v_zero;
            end
            ST_DIVN:  begin
                cmd.div_step    = !sts.div_done;
                cmd.div_start_d = sts.div_done;
            end
            ST_DIVD:  cmd.div_step = !sts.div_done;
            ST_OUT:   if (!m_tvalid_reg || m_tready) begin
                cmd.out_load  = 1'b1;
                m_tvalid_next = 1'b1;
            end
            default:  ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    `ASSERT_IMPL(a_busy_no_ready, aclk, aresetn, state_reg != ST_IDLE, !s_tready,
        "ready while busy")
    `ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_tvalid,
        "result loaded without valid")

endmodule

FILE: src/rational_mul_div_reduce.sv
// ----------------------------------------------------------------------------
// rational_mul_div_reduce
// Reduces a fraction, or multiplies/divides two fractions, in lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per transfer; tuser carries op, tdata the four
//   operands. m_ channel: one result per request; tuser carries status.
//   A request passes through load, product and a check, then the binary
//   gcd (shared trailing zeros + strip + one subtract/shift per cycle),
//   then two restoring divisions by the gcd on the shared divider, and the
//   output stage. Zero numerator or denominator skips straight from the
//   check to the output.
//   One request is in work at a time; s_tready is high only when idle.
//   A stalled result is held in the output register; the next request is
//   accepted and computed meanwhile, then waits until that result is taken.
//   Reset (aresetn low, synchronous) returns to idle with no result pending.
// ----------------------------------------------------------------------------
module rational_mul_div_reduce
    import rmdr_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [4*OPERAND_WIDTH-1:0]  s_tdata,  // a_num, a_den, b_num, b_den
    input  logic [1:0]                  s_tuser,  // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,  // res_num, res_den, zero pad
    output logic                        m_tuser   // status
);

    localparam int W = OPERAND_WIDTH;

    rmdr_cmd_t cmd;
    rmdr_sts_t sts;
    logic [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0] res_den;

    rmdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rmdr_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .op      (s_tuser),
        .a_num   (s_tdata[W-1:0]),
        .a_den   (s_tdata[2*W-1:W]),
        .b_num   (s_tdata[3*W-1:2*W]),
        .b_den   (s_tdata[4*W-1:3*W]),
        .res_num (res_num),
        .res_den (res_den),
        .status  (m_tuser)
    );

    assign m_tdata = {1'b0, res_den, res_num};

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the rational multiply/divide/reduce unit: directed edge cases
// and random requests with random stalls, checked against an inline model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import rmdr_pkg::*;

    localparam int W = OPERAND_WIDTH_DEF;

    typedef struct {
        logic [1:0]   op;
        logic [W-1:0] an, ad, bn, bd;
    } frac_req_t;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic        zero_den;
    } frac_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [4*W-1:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    frac_req_t req_q[$];
    frac_res_t ratio_q[$];
    int        errors;
    int        n_sent;
    int        n_recv;
    int        n_zero_den;
    int        hold_cycles;
    bit        drain_wait;
    bit        s_fire;
    bit        m_fire;

    rational_mul_div_reduce dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] mag_of(logic [W-1:0] v);
        return v[W-1] ? 64'(-$signed({1'b1, v})) : 64'(v);
    endfunction

    function automatic logic [63:0] gcd_of(logic [63:0] u, logic [63:0] v);
        logic [63:0] t;
        while (v != 0) begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    function automatic frac_res_t reduce_fraction(frac_req_t r);
        frac_res_t   res;
        logic [63:0] nm, dm, g;
        logic        neg;
        case (r.op)
            OP_MUL: begin
                nm = mag_of(r.an) * mag_of(r.bn);
                dm = mag_of(r.ad) * mag_of(r.bd);
                neg = r.an[W-1] ^ r.bn[W-1] ^ r.ad[W-1] ^ r.bd[W-1];
            end
            OP_DIV: begin
                nm = mag_of(r.an) * mag_of(r.bd);
                dm = mag_of(r.ad) * mag_of(r.bn);
                neg = r.an[W-1] ^ r.bd[W-1] ^ r.ad[W-1] ^ r.bn[W-1];
            end
            default: begin
                nm = mag_of(r.an);
                dm = mag_of(r.ad);
                neg = r.an[W-1] ^ r.ad[W-1];
            end
        endcase
        res = '{num: '0, den: '0, zero_den: 1'b0};
        if (dm == 0) begin
            res.zero_den = 1'b1;
        end else if (nm == 0) begin
            res.den = 31'd1;
        end else begin
            g = gcd_of(nm, dm);
            nm = nm / g;
            dm = dm / g;
            res.num = neg ? 32'(-nm) : 32'(nm);
            res.den = 31'(dm);
        end
        return res;
    endfunction

    // driver
    int          s_gap;
    frac_req_t   cur_req;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = $urandom_range(0, 18);
        end else if (s_tvalid && !s_fire) begin
        end else if (s_gap > 0 || drain_wait) begin
            s_tvalid <= 1'b0;
            if (s_gap > 0) s_gap--;
        end else if (req_q.size() > 0) begin
            cur_req = req_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= cur_req.op;
            s_tdata <= {cur_req.bd, cur_req.bn, cur_req.ad, cur_req.an};
            s_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver stall
    int m_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else if (m_fire) begin
            m_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            m_tready <= (m_gap == 0);
        end else if (m_gap > 0) begin
            m_gap--;
            m_tready <= (m_gap == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // input transfers feed the predictor, output transfers are checked
    frac_res_t exp_res;
    frac_req_t acc;
    always @(posedge aclk) begin
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        if (s_fire) begin
            acc.op = s_tuser;
            {acc.bd, acc.bn, acc.ad, acc.an} = s_tdata;
            ratio_q.push_back(reduce_fraction(acc));
            n_sent++;
        end
        if (m_fire) begin
            n_recv++;
            if (ratio_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                exp_res = ratio_q.pop_front();
                if (exp_res.zero_den) n_zero_den++;
                if (m_tdata[31:0] !== exp_res.num) begin
                    $error("res_num expected %0d got %0d",
                           $signed(exp_res.num), $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[62:32] !== exp_res.den) begin
                    $error("res_den expected %0d got %0d", exp_res.den, m_tdata[62:32]);
                    errors++;
                end
                if (m_tuser !== exp_res.zero_den) begin
                    $error("status expected %0d got %0d", exp_res.zero_den, m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return W'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
            1: return W'($urandom_range(0, 3)) - W'(1);
            2: return W'($urandom_range(0, 64)) * W'($urandom_range(1, 512));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic add_req(logic [1:0] op, logic [W-1:0] an, logic [W-1:0] ad,
                           logic [W-1:0] bn, logic [W-1:0] bd);
        frac_req_t r;
        r = '{op: op, an: an, ad: ad, bn: bn, bd: bd};
        req_q.push_back(r);
    endtask

    localparam logic [W-1:0] MAXP = 16'h7fff;
    localparam logic [W-1:0] MINN = 16'h8000;
    localparam logic [W-1:0] ONE  = 16'd1;
    localparam logic [W-1:0] MONE = 16'hffff;
    localparam logic [1:0]   OP_SPARE = 2'd3;

    initial begin
        errors = 0; n_sent = 0; n_recv = 0; n_zero_den = 0;
        hold_cycles = 0; drain_wait = 0; s_fire = 0; m_fire = 0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        add_req(OP_REDUCE, 16'd6, 16'd4, 0, 0);
        add_req(OP_REDUCE, 16'd6, -16'd4, MAXP, MINN);
        add_req(OP_REDUCE, 0, 16'd5, 0, 0);
        add_req(OP_REDUCE, 16'd5, 0, 0, 0);
        add_req(OP_REDUCE, MINN, MINN, 0, 0);
        add_req(OP_REDUCE, MINN, MAXP, 0, 0);
        add_req(OP_SPARE, -16'd12, -16'd18, MONE, MONE);
        add_req(OP_MUL, MINN, MAXP, MINN, MAXP);
        add_req(OP_MUL, MINN, ONE, MINN, ONE);
        add_req(OP_MUL, MAXP, MINN, MONE, MINN);
        add_req(OP_MUL, 0, 16'd3, 16'd7, 16'd9);
        add_req(OP_MUL, 16'd3, 0, 16'd7, 16'd9);
        add_req(OP_MUL, 16'd3, 16'd4, 16'd8, -16'd9);
        add_req(OP_DIV, 16'd3, 16'd4, 0, 16'd9);
        add_req(OP_DIV, 0, 16'd4, 16'd3, 16'd9);
        add_req(OP_DIV, MINN, ONE, ONE, MINN);
        add_req(OP_DIV, MINN, MAXP, MAXP, MINN);
        add_req(OP_DIV, 16'd1024, 16'd4096, 16'd2048, MONE);
        add_req(OP_DIV, MONE, MONE, MONE, MONE);
        wait (req_q.size() == 0);

        // long receiver hold while requests keep arriving
        hold_cycles = 1500;
        for (int i = 0; i < 30; i++)
            add_req(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                    rand_operand(), rand_operand());
        wait (req_q.size() == 0);

        // sender pause until all results are back
        drain_wait = 1;
        wait (!s_tvalid && ratio_q.size() == 0 && n_recv == n_sent);
        drain_wait = 0;

        for (int i = 0; i < 950; i++) begin
            add_req(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                    rand_operand(), rand_operand());
            if (req_q.size() > 8) wait (req_q.size() <= 8);
        end
        wait (req_q.size() == 0 && !s_tvalid);
        wait (ratio_q.size() == 0);
        repeat (300) @(posedge aclk);

        $display("Covered %0d requests (%0d with zero denominator), all ops and extremes.",
                 n_sent, n_zero_den);
        if (errors == 0 && ratio_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
